// ===== src/event_time_surface_unit_defines.svh =====
// Assertion macros used by the time surface checker.
`ifndef EVENT_TIME_SURFACE_UNIT_DEFINES_SVH
`define EVENT_TIME_SURFACE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ETSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ETSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/etsu_pkg.sv =====
// Shared constants, types and the exponential table for the time surface unit.
package etsu_pkg;

	localparam int SENSOR_WIDTH   = 640;
	localparam int SENSOR_HEIGHT  = 480;
	localparam int EXP_TABLE_BITS = 10;

	localparam int PIXELS     = SENSOR_WIDTH * SENSOR_HEIGHT;
	localparam int IDX_W      = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int TABLE_SIZE = (1 << EXP_TABLE_BITS) + 1;
	localparam int TBL_AW     = EXP_TABLE_BITS + 1;
	localparam int FRAC_BITS  = 19 - EXP_TABLE_BITS;

	localparam int X_W      = 10;
	localparam int Y_W      = 9;
	localparam int TIME_W   = 63;
	localparam int DECAY_W  = 30;
	localparam int OUT_W    = 8;

	// difference kept after the range check: d < 8 * decay
	localparam int D_W       = DECAY_W + 3;
	localparam int NUM_W     = D_W + 16 + 1;
	localparam int DIV_STEPS = 20;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(30000000);

	typedef logic [31:0] exp_table_t [TABLE_SIZE];

	typedef enum logic [1:0] {
		RES_NONE,
		RES_ZERO,
		RES_FULL,
		RES_SCALED
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     index;
		logic     mem_rd;
		logic     mem_wr;
		logic     clr_step;
		logic     check;
		logic     div_load;
		logic     div_step;
		logic     rom_rd;
		logic     interp;
		res_sel_t res_sel;
	} etsu_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_read;
		logic miss;
		logic later;
		logic far;
		logic div_last;
		logic e_big;
	} etsu_sts_t;

	// exp(-8*i/2^B) in Q1.31, built from a Taylor series of the step ratio
	function automatic exp_table_t build_exp_table();
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		exp_table_t  t;
		term = 64'd1 << 62;
		sum  = term;
		for (int k = 1; k <= 24; k++) begin
			term = (term >> (EXP_TABLE_BITS - 3)) / 64'(k);
			if ((k & 1) != 0)
				sum = sum - term;
			else
				sum = sum + term;
		end
		r = (sum + (64'd1 << 30)) >> 31;
		t[0] = 32'h8000_0000;
		for (int k = 1; k < TABLE_SIZE; k++) begin
			t[k] = 32'(((64'(t[k-1]) * r) + (64'd1 << 30)) >> 31);
		end
		return t;
	endfunction

	localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

// ===== src/event_time_surface_unit.sv =====
// Top level of the event camera time surface unit.
//
//  channel   signals                                   handshake
//  -------   ---------------------------------------   ------------------------------
//  item in   kind, pixel_x, pixel_y, time_ns           taken when start && !busy
//  result    intensity                                 one-cycle intensity_valid strobe
//  config    decay_ns                                  written when decay_ns_we is high
//
// An event write passes the index and store-write states before busy drops; no new item is
// taken until the last is done. A read that ends early (pixel outside, never written, later
// stamp, too old) ends after the check and decide states; one that runs the 20-step restoring
// divider ends after the table look-up (exponent out of range) or after interpolate and scale.
// The result strobe is high in the first cycle with busy low. After reset busy holds while the
// valid store is swept clean, one pixel a cycle. Results cannot be stalled.
module event_time_surface_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [etsu_pkg::X_W-1:0]      pixel_x,
	input  logic [etsu_pkg::Y_W-1:0]      pixel_y,
	input  logic [etsu_pkg::TIME_W-1:0]   time_ns,
	input  logic                          decay_ns_we,
	input  logic [etsu_pkg::DECAY_W-1:0]  decay_ns,
	output logic [etsu_pkg::OUT_W-1:0]    intensity,
	output logic                          intensity_valid
);

	etsu_pkg::etsu_cmd_t cmd;
	etsu_pkg::etsu_sts_t sts;

	etsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	etsu_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.decay_ns_we     (decay_ns_we),
		.decay_ns        (decay_ns),
		.kind            (kind),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.time_ns         (time_ns),
		.intensity       (intensity),
		.intensity_valid (intensity_valid)
	);

endmodule

// ===== src/etsu_ctrl.sv =====
// Controller state machine for the time surface unit.
module etsu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  etsu_pkg::etsu_sts_t sts,
	output etsu_pkg::etsu_cmd_t cmd,
	output logic               busy
);

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b00_0000_0001,
		S_IDLE   = 10'b00_0000_0010,
		S_INDEX  = 10'b00_0000_0100,
		S_MEM    = 10'b00_0000_1000,
		S_CHECK  = 10'b00_0001_0000,
		S_DECIDE = 10'b00_0010_0000,
		S_DIV    = 10'b00_0100_0000,
		S_LOOK   = 10'b00_1000_0000,
		S_INTERP = 10'b01_0000_0000,
		S_SCALE  = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_sel = etsu_pkg::RES_NONE;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_INDEX;
				end
			end
			S_INDEX: begin
				cmd.index = 1'b1;
				state_d   = S_MEM;
			end
			S_MEM: begin
				if (sts.is_read) begin
					cmd.mem_rd = 1'b1;
					state_d    = S_CHECK;
				end else begin
					cmd.mem_wr = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.miss) begin
					cmd.res_sel = etsu_pkg::RES_ZERO;
					state_d     = S_IDLE;
				end else if (sts.later) begin
					cmd.res_sel = etsu_pkg::RES_FULL;
					state_d     = S_IDLE;
				end else if (sts.far) begin
					cmd.res_sel = etsu_pkg::RES_ZERO;
					state_d     = S_IDLE;
				end else begin
					cmd.div_load = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = S_LOOK;
			end
			S_LOOK: begin
				if (sts.e_big) begin
					cmd.res_sel = etsu_pkg::RES_ZERO;
					state_d     = S_IDLE;
				end else begin
					cmd.rom_rd = 1'b1;
					state_d    = S_INTERP;
				end
			end
			S_INTERP: begin
				cmd.interp = 1'b1;
				state_d    = S_SCALE;
			end
			S_SCALE: begin
				cmd.res_sel = etsu_pkg::RES_SCALED;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== src/etsu_dp.sv =====
// Datapath: pixel stores, decay register, divider, table interpolation, result register.
module etsu_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  etsu_pkg::etsu_cmd_t               cmd,
	output etsu_pkg::etsu_sts_t               sts,
	input  logic                              decay_ns_we,
	input  logic [etsu_pkg::DECAY_W-1:0]      decay_ns,
	input  logic                              kind,
	input  logic [etsu_pkg::X_W-1:0]          pixel_x,
	input  logic [etsu_pkg::Y_W-1:0]          pixel_y,
	input  logic [etsu_pkg::TIME_W-1:0]       time_ns,
	output logic [etsu_pkg::OUT_W-1:0]        intensity,
	output logic                              intensity_valid
);

	localparam int IDX_W   = etsu_pkg::IDX_W;
	localparam int TIME_W  = etsu_pkg::TIME_W;
	localparam int DECAY_W = etsu_pkg::DECAY_W;
	localparam int D_W     = etsu_pkg::D_W;
	localparam int NUM_W   = etsu_pkg::NUM_W;
	localparam int QW      = etsu_pkg::DIV_STEPS;
	localparam int FRAC    = etsu_pkg::FRAC_BITS;
	localparam int TBITS   = etsu_pkg::EXP_TABLE_BITS;
	localparam int TBL_AW  = etsu_pkg::TBL_AW;
	localparam int OUT_W   = etsu_pkg::OUT_W;

	// captured item
	logic                       kind_q;
	logic [etsu_pkg::X_W-1:0]   px_q;
	logic [etsu_pkg::Y_W-1:0]   py_q;
	logic [TIME_W-1:0]          time_q;

	logic [IDX_W-1:0]           idx_q;
	logic                       inside_q;
	logic [IDX_W-1:0]           idx_d;
	logic                       inside_d;

	logic [DECAY_W-1:0]         decay_q;
	logic [DECAY_W-1:0]         decay_eff;

	// stores
	logic [TIME_W-1:0]          time_mem [etsu_pkg::PIXELS];
	logic                       valid_mem [etsu_pkg::PIXELS];
	logic [TIME_W-1:0]          tp_rd_q;
	logic                       vld_rd_q;
	logic [IDX_W-1:0]           clr_cnt_q;
	logic                       v_we;
	logic [IDX_W-1:0]           v_addr;

	// check stage
	logic [TIME_W:0]            diff_full;
	logic                       later_q;
	logic                       miss_q;
	logic                       far_q;
	logic [D_W-1:0]             d_q;

	// divider
	logic [NUM_W-1:0]           num;
	logic [DECAY_W-1:0]         rem_q;
	logic [QW-1:0]              quo_q;
	logic [etsu_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [DECAY_W:0]           rem_sh;
	logic [DECAY_W+1:0]         trial;

	// table and interpolation
	logic [TBL_AW-1:0]          tbl_i;
	logic [TBL_AW-1:0]          tbl_n;
	logic [31:0]                hi_q;
	logic [31:0]                lo_q;
	logic [FRAC-1:0]            f_q;
	logic [31:0]                span;
	logic [31+FRAC:0]           prod;
	logic [31:0]                v_q;
	logic [39:0]                scaled;
	logic [8:0]                 sc;
	logic [OUT_W-1:0]           sc_sat;

	logic [OUT_W-1:0]           out_q;
	logic                       out_vld_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			px_q   <= pixel_x;
			py_q   <= pixel_y;
			time_q <= time_ns;
		end
	end

	assign inside_d = (32'(px_q) < 32'(etsu_pkg::SENSOR_WIDTH)) &&
			(32'(py_q) < 32'(etsu_pkg::SENSOR_HEIGHT));
	assign idx_d = IDX_W'(32'(py_q) * 32'(etsu_pkg::SENSOR_WIDTH) + 32'(px_q));

	always_ff @(posedge clk) begin
		if (cmd.index) begin
			idx_q    <= idx_d;
			inside_q <= inside_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			decay_q <= etsu_pkg::DECAY_RESET;
		else if (decay_ns_we)
			decay_q <= decay_ns;
	end

	// a zero decay counts as one nanosecond
	assign decay_eff = (decay_q == '0) ? DECAY_W'(1) : decay_q;

	// pixel time store, no reset
	always_ff @(posedge clk) begin
		if (cmd.mem_wr && inside_q)
			time_mem[idx_q] <= time_q;
		if (cmd.mem_rd)
			tp_rd_q <= time_mem[idx_q];
	end

	// valid store, cleared by a sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr_step)
			clr_cnt_q <= clr_cnt_q + IDX_W'(1);
	end

	assign v_we   = cmd.clr_step || (cmd.mem_wr && inside_q);
	assign v_addr = cmd.clr_step ? clr_cnt_q : idx_q;

	always_ff @(posedge clk) begin
		if (v_we)
			valid_mem[v_addr] <= !cmd.clr_step;
		if (cmd.mem_rd)
			vld_rd_q <= valid_mem[idx_q];
	end

	// borrow out of the subtract means the stored time is later
	assign diff_full = {1'b0, time_q} - {1'b0, tp_rd_q};

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			later_q <= diff_full[TIME_W];
			miss_q  <= !inside_q || !vld_rd_q;
			far_q   <= diff_full[TIME_W-1:0] >= TIME_W'({decay_eff, 3'b000});
			d_q     <= diff_full[D_W-1:0];
		end
	end

	// rounded numerator; quotient stays below 2^20 so the top bits seed the remainder
	assign num = {1'b0, d_q, 16'b0} + NUM_W'(decay_eff >> 1);

	assign rem_sh = {rem_q, quo_q[QW-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, decay_eff};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= num[NUM_W-1:QW];
			quo_q <= num[QW-1:0];
		end else if (cmd.div_step) begin
			if (!trial[DECAY_W+1])
				rem_q <= trial[DECAY_W-1:0];
			else
				rem_q <= rem_sh[DECAY_W-1:0];
			quo_q <= {quo_q[QW-2:0], !trial[DECAY_W+1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_cnt_q <= '0;
		else if (cmd.div_load)
			div_cnt_q <= '0;
		else if (cmd.div_step)
			div_cnt_q <= div_cnt_q + etsu_pkg::DIV_CNT_W'(1);
	end

	// exponent is Q4.16 in quo_q; bit 19 set means e >= 8.0
	assign tbl_i = {1'b0, quo_q[QW-2 -: TBITS]};
	assign tbl_n = tbl_i + TBL_AW'(1);

	always_ff @(posedge clk) begin
		if (cmd.rom_rd) begin
			hi_q <= etsu_pkg::EXP_TABLE[tbl_i];
			lo_q <= etsu_pkg::EXP_TABLE[tbl_n];
			f_q  <= quo_q[FRAC-1:0];
		end
	end

	assign span = hi_q - lo_q;
	assign prod = (32+FRAC)'(span) * (32+FRAC)'(f_q);

	always_ff @(posedge clk) begin
		if (cmd.interp)
			v_q <= hi_q - prod[31+FRAC:FRAC];
	end

	// 255 * v rounded from Q1.31
	assign scaled = {v_q, 8'b0} - {8'b0, v_q} + 40'(32'h4000_0000);
	assign sc     = scaled[39:31];
	assign sc_sat = sc[8] ? 8'hFF : sc[7:0];

	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			etsu_pkg::RES_ZERO:   out_q <= '0;
			etsu_pkg::RES_FULL:   out_q <= 8'hFF;
			etsu_pkg::RES_SCALED: out_q <= sc_sat;
			default:              out_q <= out_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else
			out_vld_q <= (cmd.res_sel != etsu_pkg::RES_NONE);
	end

	assign intensity       = out_q;
	assign intensity_valid = out_vld_q;

	assign sts.clr_last = (32'(clr_cnt_q) == 32'(etsu_pkg::PIXELS - 1));
	assign sts.is_read  = kind_q;
	assign sts.miss     = miss_q;
	assign sts.later    = later_q;
	assign sts.far      = far_q;
	assign sts.div_last = (div_cnt_q == etsu_pkg::DIV_CNT_W'(QW - 1));
	assign sts.e_big    = quo_q[QW-1];

endmodule

// ===== src/etsu_checker.sv =====
// Port-level checks for the time surface unit, bound to the top level.
`include "event_time_surface_unit_defines.svh"

module etsu_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic intensity_valid
);

	`ETSU_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, start && !busy, busy, "busy low after accept")
	`ETSU_ASSERT_NEXT(a_no_result_after_accept, clk, arst_n, start && !busy, !intensity_valid, "result right after accept")
	`ETSU_ASSERT_NOW(a_result_when_idle, clk, arst_n, intensity_valid, !busy, "result while busy")
	`ETSU_ASSERT_NEXT(a_single_strobe, clk, arst_n, intensity_valid, !intensity_valid, "result strobe longer than one cycle")
	`ETSU_ASSERT_NEXT(a_write_no_result, clk, arst_n, start && !busy && !kind, !intensity_valid, "event item gave a result")

endmodule

bind event_time_surface_unit etsu_checker u_etsu_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.kind            (kind),
	.intensity_valid (intensity_valid)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the event time surface unit: event writes, decayed reads, decay settings.
module testbench;

	localparam int SENSOR_WIDTH   = etsu_pkg::SENSOR_WIDTH;
	localparam int SENSOR_HEIGHT  = etsu_pkg::SENSOR_HEIGHT;
	localparam int EXP_TABLE_BITS = etsu_pkg::EXP_TABLE_BITS;
	localparam int X_W            = etsu_pkg::X_W;
	localparam int Y_W            = etsu_pkg::Y_W;
	localparam int TIME_W         = etsu_pkg::TIME_W;
	localparam int DECAY_W        = etsu_pkg::DECAY_W;
	localparam int OUT_W          = etsu_pkg::OUT_W;
	localparam logic [DECAY_W-1:0] DECAY_RESET = etsu_pkg::DECAY_RESET;

	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam int FRAC_W         = 19 - EXP_TABLE_BITS;
	localparam int CURVE_LEN      = (1 << EXP_TABLE_BITS) + 1;
	localparam int SETTLE_CYCLES  = 40;
	// covers the valid-store sweep after reset with a wide margin
	localparam int WATCHDOG_LIMIT = 1000000;
	localparam int PHASE_ITEMS    = 64;

	localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
	localparam logic [DECAY_W-1:0] DECAY_MAX = {DECAY_W{1'b1}};

	typedef struct {
		logic [OUT_W-1:0]  level;
		logic [X_W-1:0]    x;
		logic [Y_W-1:0]    y;
		logic [TIME_W-1:0] t;
	} surface_read_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                kind = KIND_EVENT;
	logic [X_W-1:0]      pixel_x = '0;
	logic [Y_W-1:0]      pixel_y = '0;
	logic [TIME_W-1:0]   time_ns = '0;
	logic                decay_ns_we = 1'b0;
	logic [DECAY_W-1:0]  decay_ns = '0;
	logic [OUT_W-1:0]    intensity;
	logic                intensity_valid;

	// predictor state
	logic [31:0]         decay_curve [CURVE_LEN];
	logic [TIME_W-1:0]   surface_stamp [int unsigned];
	int unsigned         lit_pixels [$];
	logic [DECAY_W-1:0]  decay_setting = DECAY_RESET;
	surface_read_t       pending_reads [$];
	surface_read_t       oldest_read;

	bit          idle_en = 1'b1;
	int unsigned quiet_cycles = 0;
	int unsigned fail_count = 0;
	int unsigned events_sent = 0;
	int unsigned reads_sent = 0;
	int unsigned partial_reads = 0;
	int unsigned reads_checked = 0;
	int unsigned decay_writes = 0;

	event_time_surface_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.time_ns         (time_ns),
		.decay_ns_we     (decay_ns_we),
		.decay_ns        (decay_ns),
		.intensity       (intensity),
		.intensity_valid (intensity_valid)
	);

	always #2 clk = ~clk;

	// exp(-8*i/2^B) in Q1.31 from the Taylor sum of one step ratio
	initial begin
		logic [63:0] step_term;
		logic [63:0] step_sum;
		logic [63:0] ratio;
		step_term = 64'd1 << 62;
		step_sum  = step_term;
		for (int k = 1; k <= 24; k++) begin
			step_term = (step_term >> (EXP_TABLE_BITS - 3)) / 64'(k);
			if (k % 2 == 1)
				step_sum = step_sum - step_term;
			else
				step_sum = step_sum + step_term;
		end
		ratio = (step_sum + (64'd1 << 30)) >> 31;
		decay_curve[0] = 32'h8000_0000;
		for (int k = 1; k < CURVE_LEN; k++)
			decay_curve[k] = 32'((64'(decay_curve[k-1]) * ratio + (64'd1 << 30)) >> 31);
	end

	function automatic logic [63:0] effective_decay();
		return (decay_setting == '0) ? 64'd1 : 64'(decay_setting);
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		return TIME_W'({$urandom, $urandom});
	endfunction

	function automatic logic [OUT_W-1:0] decayed_intensity(input logic [TIME_W-1:0] query,
			input logic [TIME_W-1:0] stamp);
		logic [63:0] span;
		logic [63:0] dt;
		logic [63:0] expo;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] frac;
		logic [63:0] level;
		int unsigned slot;
		span = effective_decay();
		if (stamp > query)
			return 8'd255;
		dt = 64'(query - stamp);
		if (dt >= span * 64'd8)
			return 8'd0;
		expo = ((dt << 16) + span / 64'd2) / span;
		if (expo >= (64'd8 << 16))
			return 8'd0;
		slot  = 32'(expo >> FRAC_W);
		frac  = expo & ((64'd1 << FRAC_W) - 64'd1);
		hi    = 64'(decay_curve[slot]);
		lo    = 64'(decay_curve[slot + 1]);
		level = hi - (((hi - lo) * frac) >> FRAC_W);
		level = (64'd255 * level + (64'd1 << 30)) >> 31;
		return (level > 64'd255) ? 8'd255 : level[7:0];
	endfunction

	// drive one item, hold it until taken, then update the surface model
	task automatic send_item(input logic k, input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
			input logic [TIME_W-1:0] t);
		int unsigned idx;
		bit on_sensor;
		surface_read_t rd;
		@(negedge clk);
		start   <= 1'b1;
		kind    <= k;
		pixel_x <= x;
		pixel_y <= y;
		time_ns <= t;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
		start <= 1'b0;
		on_sensor = (x < SENSOR_WIDTH) && (y < SENSOR_HEIGHT);
		idx = int'(y) * SENSOR_WIDTH + int'(x);
		if (k == KIND_EVENT) begin
			if (on_sensor) begin
				if (!surface_stamp.exists(idx))
					lit_pixels.push_back(idx);
				surface_stamp[idx] = t;
			end
			events_sent++;
		end else begin
			rd.x = x;
			rd.y = y;
			rd.t = t;
			rd.level = (on_sensor && surface_stamp.exists(idx)) ?
				decayed_intensity(t, surface_stamp[idx]) : 8'd0;
			if (rd.level != 8'd0 && rd.level != 8'd255)
				partial_reads++;
			pending_reads.push_back(rd);
			reads_sent++;
		end
	endtask

	task automatic sender_pause();
		if (idle_en && $urandom_range(0, 3) == 0) begin
			// sometimes let the gap start right as the unit goes idle
			if ($urandom_range(0, 1) == 1) begin
				do @(posedge clk); while (busy !== 1'b0);
			end
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		while (pending_reads.size() != 0) @(posedge clk);
		// event writes give no strobe, so give the last one time to finish
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic set_decay(input logic [DECAY_W-1:0] value);
		wait_drained();
		@(negedge clk);
		decay_ns_we <= 1'b1;
		decay_ns    <= value;
		@(negedge clk);
		decay_ns_we <= 1'b0;
		decay_setting = value;
		decay_writes++;
	endtask

	task automatic random_item();
		int unsigned pick;
		int unsigned idx;
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		logic [TIME_W-1:0] t;
		logic [63:0] span;
		span = effective_decay();
		pick = $urandom_range(0, 99);
		if (pick < 40 || lit_pixels.size() == 0) begin
			if (lit_pixels.size() != 0 && $urandom_range(0, 3) == 0) begin
				idx = lit_pixels[$urandom_range(0, lit_pixels.size() - 1)];
				x = X_W'(idx % SENSOR_WIDTH);
				y = Y_W'(idx / SENSOR_WIDTH);
			end else if ($urandom_range(0, 9) == 0) begin
				x = X_W'($urandom);
				y = Y_W'($urandom);
			end else begin
				x = X_W'($urandom_range(0, SENSOR_WIDTH - 1));
				y = Y_W'($urandom_range(0, SENSOR_HEIGHT - 1));
			end
			send_item(KIND_EVENT, x, y, rand_time());
		end else if (pick < 88) begin
			idx = lit_pixels[$urandom_range(0, lit_pixels.size() - 1)];
			x = X_W'(idx % SENSOR_WIDTH);
			y = Y_W'(idx / SENSOR_WIDTH);
			case ($urandom_range(0, 19))
				0, 1: t = TIME_W'(surface_stamp[idx] - 64'($urandom_range(1, 1000)));
				2: t = rand_time();
				default: t = TIME_W'(surface_stamp[idx] + ({$urandom, $urandom} % (span * 9 + 1)));
			endcase
			send_item(KIND_READ, x, y, t);
		end else begin
			send_item(KIND_READ, X_W'($urandom), Y_W'($urandom), rand_time());
		end
		sender_pause();
	endtask

	// reads against the reset decay, covering every special case
	task automatic test_directed();
		send_item(KIND_READ,  10'd0,   9'd0,   63'd0);
		send_item(KIND_EVENT, 10'd0,   9'd0,   63'd1000);
		send_item(KIND_READ,  10'd0,   9'd0,   63'd1000);
		send_item(KIND_READ,  10'd0,   9'd0,   63'd999);
		send_item(KIND_READ,  10'd0,   9'd0,   63'd1000 + 63'(DECAY_RESET));
		send_item(KIND_READ,  10'd0,   9'd0,   63'd999 + 63'(DECAY_RESET) * 8);
		send_item(KIND_READ,  10'd0,   9'd0,   63'd1000 + 63'(DECAY_RESET) * 8);
		send_item(KIND_EVENT, 10'd639, 9'd479, TIME_MAX);
		send_item(KIND_READ,  10'd639, 9'd479, TIME_MAX);
		send_item(KIND_READ,  10'd639, 9'd479, 63'd0);
		send_item(KIND_EVENT, 10'd640, 9'd0,   63'd5);
		send_item(KIND_READ,  10'd640, 9'd0,   63'd5);
		send_item(KIND_EVENT, 10'd1023, 9'd511, TIME_MAX);
		send_item(KIND_READ,  10'd1023, 9'd511, TIME_MAX);
		send_item(KIND_EVENT, 10'd0,   9'd480, 63'd7);
		send_item(KIND_READ,  10'd0,   9'd480, 63'd7);
		send_item(KIND_EVENT, 10'd0,   9'd479, 63'd0);
		send_item(KIND_READ,  10'd0,   9'd479, TIME_MAX);
	endtask

	// zero, one, the largest and a one second time constant
	task automatic test_decay_extremes();
		logic [DECAY_W-1:0] settings [4];
		logic [TIME_W-1:0] base;
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		logic [63:0] span;
		settings = '{'0, DECAY_W'(1), DECAY_MAX, DECAY_W'(1000000000)};
		foreach (settings[s]) begin
			set_decay(settings[s]);
			span = effective_decay();
			base = rand_time() >> 1;
			x = X_W'($urandom_range(0, SENSOR_WIDTH - 1));
			y = Y_W'($urandom_range(0, SENSOR_HEIGHT - 1));
			send_item(KIND_EVENT, x, y, base);
			send_item(KIND_READ, x, y, TIME_W'(base + span / 3));
			send_item(KIND_READ, x, y, TIME_W'(base + span));
			send_item(KIND_READ, x, y, TIME_W'(base + span * 8 - 1));
			send_item(KIND_READ, x, y, TIME_W'(base + span * 8));
		end
	endtask

	task automatic test_random_phases();
		logic [DECAY_W-1:0] settings [5];
		settings = '{DECAY_RESET, DECAY_W'($urandom_range(2, 5000)), DECAY_W'($urandom),
			DECAY_W'(1000000000), DECAY_W'($urandom_range(1, 200000))};
		foreach (settings[s]) begin
			set_decay(settings[s]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (s == 1 && n == PHASE_ITEMS / 2)
					wait_drained();
				random_item();
			end
		end
	endtask

	// back-to-back items with no sender gaps
	task automatic test_steady_tail();
		idle_en = 1'b0;
		set_decay(DECAY_W'($urandom_range(1000, 50000000)));
		for (int n = 0; n < PHASE_ITEMS; n++)
			random_item();
	endtask

	always @(posedge clk) begin
		if (arst_n && intensity_valid === 1'b1) begin
			if (pending_reads.size() == 0) begin
				$error("intensity: expected nothing, actual %0d", intensity);
				fail_count++;
			end else begin
				oldest_read = pending_reads.pop_front();
				if (intensity !== oldest_read.level) begin
					$error("intensity: expected %0d, actual %0d (x=%0d y=%0d t=%0d)",
						oldest_read.level, intensity, oldest_read.x, oldest_read.y,
						oldest_read.t);
					fail_count++;
				end
				reads_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || intensity_valid === 1'b1)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item or result for %0d cycles", quiet_cycles);
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		wait_drained();
		test_directed();
		test_decay_extremes();
		test_random_phases();
		test_steady_tail();
		wait_drained();
		$display("covered %0d event writes and %0d reads (%0d checked, %0d partly decayed)",
			events_sent, reads_sent, reads_checked, partial_reads);
		$display("over %0d decay register writes, zero and full scale included", decay_writes);
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
